@@ hw/rtl/exec_image_table_validator_defines.svh @@
// ----------------------------------------------------------------------------
// Image table validator assertion macros
// Concurrent assertion helpers for the validator controller.
// ----------------------------------------------------------------------------
`ifndef EXEC_IMAGE_TABLE_VALIDATOR_DEFINES_SVH
`define EXEC_IMAGE_TABLE_VALIDATOR_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define EITV_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Implication with the consequent checked in the cycle after the antecedent.
`define EITV_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ hw/rtl/eitv_pkg.sv @@
// ----------------------------------------------------------------------------
// Image table validator package
// Types, constants and status codes shared by the validator modules.
// ----------------------------------------------------------------------------
package eitv_pkg;

	localparam int MaxSections = 16;
	localparam int IdxW = $clog2(MaxSections);
	localparam int CntW = 8;

	localparam logic [32:0] ImgSizeLimit = 33'h004000000;
	localparam logic [63:0] ResvLo = 64'h0000_0000_8000_0000;
	localparam logic [63:0] ResvHi = 64'h0000_0000_D000_0000;

	localparam int FlagZero = 0;
	localparam int FlagExec = 1;
	localparam int FlagWrite = 2;

	typedef enum logic [2:0] {
		ST_OK    = 3'd0,
		ST_HDR   = 3'd1,
		ST_MAGIC = 3'd2,
		ST_ARCH  = 3'd3,
		ST_SEC   = 3'd4,
		ST_OVF   = 3'd5,
		ST_OVL   = 3'd6,
		ST_ENTRY = 3'd7
	} status_t;

	typedef enum logic [2:0] {
		REG_MAGIC   = 3'd0,
		REG_VERSION = 3'd1,
		REG_ARCH    = 3'd2,
		REG_MIN     = 3'd3,
		REG_MAX     = 3'd4
	} reg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_COLLECT,
		S_CHECK,
		S_PAIR,
		S_ENTRY,
		S_RESULT
	} state_t;

	// Controller to datapath.
	typedef struct packed {
		logic             hdr_load;
		logic             sec_write;
		logic [IdxW-1:0]  wr_idx;
		logic             rd_a;
		logic [IdxW-1:0]  idx_a;
		logic             rd_b;
		logic [IdxW-1:0]  idx_b;
		logic             clr_exec;
	} dp_cmd_t;

	// Datapath to controller; entry fields are valid the cycle after a read, hdr_status is combinational.
	typedef struct packed {
		status_t hdr_status;
		status_t sec_status;
		logic    overlap;
		logic    entry_hit;
		logic    any_exec;
	} dp_stat_t;

endpackage

@@ hw/rtl/eitv_datapath.sv @@
// ----------------------------------------------------------------------------
// Image table validator datapath
// Header checks, section table memory and the per-section and pairwise tests.
// ----------------------------------------------------------------------------
module eitv_datapath import eitv_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  dp_cmd_t     cmd,
	input  logic [63:0] addr_word,
	input  logic [31:0] size_word,
	input  logic [31:0] offset_word,
	input  logic [31:0] length_word,
	input  logic [31:0] magic_word,
	input  logic [7:0]  hdr_version,
	input  logic [15:0] arch_code,
	input  logic [7:0]  section_total,
	input  logic [2:0]  section_flags,
	input  logic [31:0] cfg_magic,
	input  logic [7:0]  cfg_version,
	input  logic [15:0] cfg_arch,
	input  logic [63:0] cfg_min,
	input  logic [63:0] cfg_max,
	output dp_stat_t    stat
);

	logic [31:0] vstart_mem [MaxSections];
	logic [31:0] vsize_mem  [MaxSections];
	logic [31:0] roff_mem   [MaxSections];
	logic [31:0] rsize_mem  [MaxSections];
	logic [2:0]  attr_mem   [MaxSections];

	logic [31:0] img_size_q, entry_q, file_size_q;
	logic [31:0] a_start_q, a_size_q, a_roff_q, a_rsize_q;
	logic [2:0]  a_attr_q;
	logic [31:0] b_start_q, b_size_q;
	logic        any_exec_q;

	// Header checks, all evaluated side by side and prioritized.
	logic [63:0] base;
	logic [64:0] end_x;
	logic [63:0] end_w;
	status_t     hdr_st;

	assign base = addr_word;
	assign end_x = {1'b0, addr_word} + {33'd0, size_word};
	assign end_w = end_x[63:0];

	always_comb begin
		hdr_st = ST_OK;
		if (magic_word != cfg_magic) hdr_st = ST_MAGIC;
		else if (hdr_version != cfg_version) hdr_st = ST_HDR;
		else if (arch_code != cfg_arch) hdr_st = ST_ARCH;
		else if (section_total == '0 || {24'd0, section_total} > 32'(MaxSections))
			hdr_st = ST_HDR;
		else if (size_word == '0 || {1'b0, size_word} > ImgSizeLimit) hdr_st = ST_HDR;
		else if (base < cfg_min) hdr_st = ST_SEC;
		else if (end_x[64] || end_w > cfg_max) hdr_st = ST_OVF;
		else if ((base >= ResvLo && base < ResvHi) || (end_w > ResvLo && end_w <= ResvHi))
			hdr_st = ST_SEC;
		else if (base[11:0] != 12'd0) hdr_st = ST_HDR;
	end

	assign stat.hdr_status = hdr_st;

	always_ff @(posedge clk) begin
		if (cmd.hdr_load) begin
			img_size_q <= size_word;
			entry_q <= offset_word;
			file_size_q <= length_word;
		end
		if (cmd.sec_write) begin
			vstart_mem[cmd.wr_idx] <= addr_word[31:0];
			vsize_mem[cmd.wr_idx] <= size_word;
			roff_mem[cmd.wr_idx] <= offset_word;
			rsize_mem[cmd.wr_idx] <= length_word;
			attr_mem[cmd.wr_idx] <= section_flags;
		end
		if (cmd.rd_a) begin
			a_start_q <= vstart_mem[cmd.idx_a];
			a_size_q <= vsize_mem[cmd.idx_a];
			a_roff_q <= roff_mem[cmd.idx_a];
			a_rsize_q <= rsize_mem[cmd.idx_a];
			a_attr_q <= attr_mem[cmd.idx_a];
		end
		if (cmd.rd_b) begin
			b_start_q <= vstart_mem[cmd.idx_b];
			b_size_q <= vsize_mem[cmd.idx_b];
		end
	end

	// Per-section checks on the A entry.
	logic [32:0] a_end, b_end, f_end;
	status_t sec_st;

	assign a_end = {1'b0, a_start_q} + {1'b0, a_size_q};
	assign b_end = {1'b0, b_start_q} + {1'b0, b_size_q};
	assign f_end = {1'b0, a_roff_q} + {1'b0, a_rsize_q};

	always_comb begin
		sec_st = ST_OK;
		if (!a_attr_q[FlagZero] && f_end > {1'b0, file_size_q}) sec_st = ST_OVF;
		else if (a_attr_q[FlagZero] && a_rsize_q != '0) sec_st = ST_HDR;
		else if (a_end > {1'b0, img_size_q}) sec_st = ST_OVF;
		else if (a_rsize_q > a_size_q) sec_st = ST_HDR;
		else if (a_attr_q[FlagExec] && a_attr_q[FlagWrite]) sec_st = ST_SEC;
	end

	assign stat.sec_status = sec_st;
	assign stat.overlap = ({1'b0, a_start_q} < b_end) && ({1'b0, b_start_q} < a_end);
	assign stat.entry_hit = a_attr_q[FlagExec] && entry_q >= a_start_q
		&& {1'b0, entry_q} < a_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_exec_q <= 1'b0;
		end else if (cmd.clr_exec) begin
			any_exec_q <= 1'b0;
		end else if (cmd.rd_a) begin
			any_exec_q <= any_exec_q | attr_mem[cmd.idx_a][FlagExec];
		end
	end

	assign stat.any_exec = any_exec_q;

endmodule

@@ hw/rtl/eitv_ctrl.sv @@
// ----------------------------------------------------------------------------
// Image table validator controller
// Sequences header intake, section collection and the table check passes.
// ----------------------------------------------------------------------------
`include "exec_image_table_validator_defines.svh"

module eitv_ctrl import eitv_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_fire,
	input  logic       in_op,
	input  logic [7:0] section_total,
	output logic       in_ready,
	input  logic       out_ready,
	output logic       out_valid,
	output logic [2:0] out_status,
	output dp_cmd_t    cmd,
	input  dp_stat_t   stat
);

	state_t state_q, state_d;
	logic [CntW-1:0] expect_q, recv_q;
	logic [IdxW-1:0] i_q, j_q;
	logic [CntW-1:0] i_d_w, j_d_w;
	logic [IdxW-1:0] i_d, j_d;
	logic [CntW-1:0] expect_d, recv_d;
	logic [2:0] status_q, status_d;
	logic       pend_q, pend_d;
	logic       last_q, last_d;

	// pend_q marks the cycle after a read, when stat reflects the entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			expect_q <= '0;
			recv_q <= '0;
			i_q <= '0;
			j_q <= '0;
			status_q <= ST_OK;
			pend_q <= 1'b0;
			last_q <= 1'b0;
		end else begin
			state_q <= state_d;
			expect_q <= expect_d;
			recv_q <= recv_d;
			i_q <= i_d;
			j_q <= j_d;
			status_q <= status_d;
			pend_q <= pend_d;
			last_q <= last_d;
		end
	end

	assign in_ready = (state_q == S_IDLE) || (state_q == S_COLLECT);
	assign out_valid = (state_q == S_RESULT);
	assign out_status = status_q;

	always_comb begin
		state_d = state_q;
		expect_d = expect_q;
		recv_d = recv_q;
		i_d_w = {{(CntW-IdxW){1'b0}}, i_q};
		j_d_w = {{(CntW-IdxW){1'b0}}, j_q};
		status_d = status_q;
		pend_d = 1'b0;
		last_d = last_q;
		cmd = '0;
		cmd.wr_idx = recv_q[IdxW-1:0];
		cmd.idx_a = i_q;
		cmd.idx_b = j_q;
		unique case (state_q)
			S_IDLE, S_COLLECT: begin
				if (in_fire && !in_op) begin
					if (stat.hdr_status != ST_OK) begin
						status_d = stat.hdr_status;
						state_d = S_RESULT;
					end else begin
						cmd.hdr_load = 1'b1;
						expect_d = section_total;
						recv_d = '0;
						state_d = S_COLLECT;
					end
				end else if (in_fire && state_q == S_COLLECT) begin
					cmd.sec_write = 1'b1;
					recv_d = recv_q + 1'b1;
					if (recv_d >= expect_q) begin
						state_d = S_CHECK;
						i_d_w = '0;
						cmd.clr_exec = 1'b1;
					end
				end
			end
			S_CHECK: begin
				// Read entry i; the cycle after, test it.
				if (!pend_q) begin
					cmd.rd_a = 1'b1;
					pend_d = 1'b1;
				end else if (stat.sec_status != ST_OK) begin
					status_d = stat.sec_status;
					state_d = S_RESULT;
				end else if ({{(CntW-IdxW){1'b0}}, i_q} + 1'b1 < expect_q) begin
					j_d_w = {{(CntW-IdxW){1'b0}}, i_q} + 1'b1;
					state_d = S_PAIR;
				end else begin
					state_d = S_ENTRY;
					i_d_w = '0;
				end
			end
			S_PAIR: begin
				if (!pend_q) begin
					cmd.rd_b = 1'b1;
					pend_d = 1'b1;
					last_d = ({{(CntW-IdxW){1'b0}}, j_q} + 1'b1 >= expect_q);
				end else if (stat.overlap) begin
					status_d = ST_OVL;
					state_d = S_RESULT;
				end else if (last_q) begin
					i_d_w = {{(CntW-IdxW){1'b0}}, i_q} + 1'b1;
					state_d = S_CHECK;
				end else begin
					j_d_w = {{(CntW-IdxW){1'b0}}, j_q} + 1'b1;
				end
			end
			S_ENTRY: begin
				if (!stat.any_exec) begin
					status_d = ST_ENTRY;
					state_d = S_RESULT;
				end else if (!pend_q) begin
					cmd.rd_a = 1'b1;
					pend_d = 1'b1;
					last_d = ({{(CntW-IdxW){1'b0}}, i_q} + 1'b1 >= expect_q);
				end else if (stat.entry_hit) begin
					status_d = ST_OK;
					state_d = S_RESULT;
				end else if (last_q) begin
					status_d = ST_ENTRY;
					state_d = S_RESULT;
				end else begin
					i_d_w = {{(CntW-IdxW){1'b0}}, i_q} + 1'b1;
				end
			end
			S_RESULT: begin
				if (out_ready) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
		i_d = i_d_w[IdxW-1:0];
		j_d = j_d_w[IdxW-1:0];
	end

	`EITV_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, in_fire, in_ready)
	`EITV_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(out_status))
	`EITV_ASSERT_IMPL(a_write_in_range, clk, arst_n, cmd.sec_write, recv_q < expect_q)
	`EITV_ASSERT_NEXT(a_hdr_fail_result, clk, arst_n, in_fire && !in_op && stat.hdr_status != ST_OK, out_valid)

endmodule

@@ hw/rtl/exec_image_table_validator.sv @@
// ----------------------------------------------------------------------------
// Executable image table validator
// Checks an image header, collects its section table and reports one status.
// ----------------------------------------------------------------------------
// Channel   Direction  Content
// s_axis    in         header or section item (tuser = operation)
// m_axis    out        3-bit status per finished check
// apb       in         five configuration registers at 8*i
//
// A header is checked in the cycle it is accepted; a failure is shown next cycle.
// Sections are taken one per cycle; the table check then reads the section
// memory one entry at a time and tests each entry before the next is read.
// Input is not taken while a table is checked or a status waits on m_axis.
// Reset clears control state and loads the register reset values.
module exec_image_table_validator import eitv_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: addr_word, size_word, offset_word, length_word, magic_word,
	// hdr_version, arch_code, section_total, section_flags (lowest first)
	input  logic [231:0] s_axis_tdata,
	// tuser: operation
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: status
	output logic [7:0]   m_axis_tdata,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [5:0]   paddr,
	input  logic [63:0]  pwdata,
	output logic [63:0]  prdata,
	output logic         pready
);

	logic [31:0] magic_q;
	logic [7:0]  version_q;
	logic [15:0] arch_q;
	logic [63:0] min_q, max_q;
	reg_idx_t    reg_sel;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign reg_sel = reg_idx_t'(paddr[5:3]);
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= '0;
			version_q <= 8'd1;
			arch_q <= '0;
			min_q <= 64'd4096;
			max_q <= 64'h0000_7FFF_FFFF_FFFF;
		end else if (cfg_wr && paddr[2:0] == 3'd0) begin
			unique case (reg_sel)
				REG_MAGIC:   magic_q <= pwdata[31:0];
				REG_VERSION: version_q <= pwdata[7:0];
				REG_ARCH:    arch_q <= pwdata[15:0];
				REG_MIN:     min_q <= pwdata;
				REG_MAX:     max_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_MAGIC:   prdata = {32'd0, magic_q};
			REG_VERSION: prdata = {56'd0, version_q};
			REG_ARCH:    prdata = {48'd0, arch_q};
			REG_MIN:     prdata = min_q;
			REG_MAX:     prdata = max_q;
			default:     prdata = '0;
		endcase
	end

	dp_cmd_t  cmd;
	dp_stat_t stat;
	logic     in_fire;
	logic [2:0] status;

	assign in_fire = s_axis_tvalid && s_axis_tready;
	assign m_axis_tdata = {5'd0, status};

	eitv_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_fire(in_fire),
		.in_op(s_axis_tuser),
		.section_total(s_axis_tdata[223:216]),
		.in_ready(s_axis_tready),
		.out_ready(m_axis_tready),
		.out_valid(m_axis_tvalid),
		.out_status(status),
		.cmd(cmd),
		.stat(stat)
	);

	eitv_datapath u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.addr_word(s_axis_tdata[63:0]),
		.size_word(s_axis_tdata[95:64]),
		.offset_word(s_axis_tdata[127:96]),
		.length_word(s_axis_tdata[159:128]),
		.magic_word(s_axis_tdata[191:160]),
		.hdr_version(s_axis_tdata[199:192]),
		.arch_code(s_axis_tdata[215:200]),
		.section_total(s_axis_tdata[223:216]),
		.section_flags(s_axis_tdata[226:224]),
		.cfg_magic(magic_q),
		.cfg_version(version_q),
		.cfg_arch(arch_q),
		.cfg_min(min_q),
		.cfg_max(max_q),
		.stat(stat)
	);

endmodule
